[sv/lfo_waveform_generator_unit_defines.svh]
// Assertion macros shared by the LFO waveform generator RTL.
`ifndef LFO_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH
`define LFO_WAVEFORM_GENERATOR_UNIT_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define LFO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an implication holds on every rising clock edge outside reset.
`define LFO_ASSERT_IMPL(label, ante, cons, msg) \
  `LFO_ASSERT(label, (ante) |-> (cons), msg)

`endif

[sv/lfo_pkg.sv]
// Shared types, constants and sine polynomial for the LFO waveform generator.
`timescale 1ns / 1ps

package lfo_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SEL   = 2'd1;

  // Field widths
  localparam int unsigned STEP_W  = 31;
  localparam int unsigned WAVE_W  = 3;
  localparam int unsigned COUNT_W = 13;
  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned P32_W   = 32;
  localparam int unsigned SINE_W  = 16;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd894785;

  // Sine amplitude at full scale and Q2.30 constants
  localparam logic [SINE_W-1:0] SINE_FULL   = 16'd32768;
  localparam logic [63:0]       Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0]       Q30_HALF_PI = 64'd1686629713;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_TRIANGLE = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_SAW      = 3'd3,
    WAVE_INV_SAW  = 3'd4
  } wave_e;

  // Degree-nine Taylor sine of a Q2.30 angle, rounded to Q1.15 and clamped.
  function automatic logic [SINE_W-1:0] sine_poly(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << 14)) >> 15;
    if (s > 64'(SINE_FULL)) begin
      s = 64'(SINE_FULL);
    end
    return s[SINE_W-1:0];
  endfunction

  // Drop the low 16 bits of a Q2.32 value and saturate at 65535.
  function automatic logic [LEVEL_W-1:0] q32_to_level(input logic [33:0] v);
    logic [LEVEL_W-1:0] lv;
    lv = (v[33:32] != 2'b00) ? {LEVEL_W{1'b1}} : v[31:16];
    return lv;
  endfunction

endpackage

[sv/lfo_sine_rom.sv]
// Quarter-wave sine table with registered read, built at elaboration.
`timescale 1ns / 1ps

module lfo_sine_rom #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [$clog2(DEPTH+1)-1:0]         addr_i,
  output logic [lfo_pkg::SINE_W-1:0]         data_o
);
  import lfo_pkg::*;

  localparam int unsigned ENTRIES = DEPTH + 1;

  typedef logic [SINE_W-1:0] rom_t [ENTRIES];

  // Fill every entry from the sine polynomial.
  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] x;
    for (int k = 0; k < ENTRIES; k++) begin
      x    = (64'(k) * Q30_HALF_PI) / 64'(DEPTH);
      r[k] = sine_poly(x);
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [SINE_W-1:0] data_q;

  // Register the read on advance
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ROM[addr_i];
    end
  end

  assign data_o = data_q;

endmodule

[sv/lfo_waveform_generator_unit.sv]
// Top level of the LFO waveform generator: phase accumulator and wave shaping.
//
// Usage: configure phase_step (index 0) and waveform_select (index 1) through
// the cfg write channel; cfg_ready_o is always high. Each input beat carries
// sample_count and restart; restart clears the phase before it advances by
// sample_count (clamped to MAX_BLOCK_SAMPLES) times phase_step. Each input
// beat yields one output beat with the waveform level and the new phase.
// Each accepted beat passes in order through the input stage, the sine table
// read stage and the output register, whose valid flag drives out_valid_o.
// Throughput: one beat per cycle while the output is not stalled, bounded by
// the multiply-add feedback loop on the phase accumulator.
// A stalled receiver holds the output register; in_ready_o drops only once
// all three stages hold beats and out_ready_i is low.
// Reset clears the phase and the pipeline, and loads the register defaults
// (sine, step 894785). The sine table is constant logic and needs no fill.
`timescale 1ns / 1ps
`include "lfo_waveform_generator_unit_defines.svh"

module lfo_waveform_generator_unit #(
  parameter int unsigned PHASE_BITS        = 32,
  parameter int unsigned SINE_TABLE_DEPTH  = 1024,
  parameter int unsigned MAX_BLOCK_SAMPLES = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lfo_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lfo_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lfo_pkg::COUNT_W-1:0]     sample_count_i,
  input  logic                            restart_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lfo_pkg::LEVEL_W-1:0]     level_o,
  output logic [lfo_pkg::P32_W-1:0]       phase_now_o
);
  import lfo_pkg::*;

  localparam int unsigned PROD_W  = COUNT_W + STEP_W;
  localparam int unsigned SUM_W   = (PHASE_BITS > PROD_W) ? PHASE_BITS : PROD_W;
  localparam int unsigned ADDR_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned FRAC_W  = 30;
  localparam int unsigned IDXP_W  = FRAC_W + ADDR_W;

  // Configuration registers
  logic [STEP_W-1:0] step_q;
  logic [WAVE_W-1:0] wave_sel_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= STEP_RESET;
      wave_sel_q <= WAVE_SINE;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PHASE_STEP: step_q     <= cfg_data_i[STEP_W-1:0];
        CFG_WAVE_SEL:   wave_sel_q <= cfg_data_i[WAVE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advance enables
  logic s1_v_q, s2_v_q, out_v_q;
  logic en1, en2, en3, accept;

  assign en3        = !out_v_q || out_ready_i;
  assign en2        = !s2_v_q || en3;
  assign en1        = !s1_v_q || en2;
  assign in_ready_o = en1;
  assign accept     = in_valid_i && en1;

  // Clamp the block length and advance the phase
  logic [COUNT_W-1:0]    count_sat;
  logic [PROD_W-1:0]     prod;
  logic [PHASE_BITS-1:0] acc_q, acc_base, acc_d;
  logic [SUM_W-1:0]      sum;
  logic [P32_W-1:0]      p32_d;

  assign count_sat = ({4'b0, sample_count_i} > 17'(MAX_BLOCK_SAMPLES)) ?
                     COUNT_W'(MAX_BLOCK_SAMPLES) : sample_count_i;
  assign prod      = PROD_W'(count_sat) * PROD_W'(step_q);
  assign acc_base  = restart_i ? '0 : acc_q;
  assign sum       = SUM_W'(acc_base) + SUM_W'(prod);
  assign acc_d     = sum[PHASE_BITS-1:0];

  if (PHASE_BITS >= P32_W) begin : g_top_wide
    assign p32_d = acc_d[PHASE_BITS-1 -: P32_W];
  end else begin : g_top_narrow
    assign p32_d = {acc_d, {(P32_W - PHASE_BITS){1'b0}}};
  end

  logic [P32_W-1:0] s1_p32_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (accept) begin
        acc_q <= acc_d;
      end
      if (en1) begin
        s1_v_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_p32_q <= p32_d;
    end
  end

  // Locate the table entry inside the quadrant
  logic [IDXP_W-1:0] idx_prod;
  logic [ADDR_W-1:0] idx, rom_addr;
  logic [SINE_W-1:0] rom_data;

  assign idx_prod = IDXP_W'(s1_p32_q[FRAC_W-1:0]) * IDXP_W'(SINE_TABLE_DEPTH);
  assign idx      = idx_prod[IDXP_W-1:FRAC_W];
  assign rom_addr = s1_p32_q[FRAC_W] ? (ADDR_W'(SINE_TABLE_DEPTH) - idx) : idx;

  lfo_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .en_i   (en2),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  logic [P32_W-1:0] s2_p32_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_p32_q <= s1_p32_q;
    end
  end

  // Shape the level from the phase
  logic [33:0]        p34;
  logic [33:0]        sine_sum;
  logic [LEVEL_W-1:0] level_d;

  localparam logic [33:0] HALF34      = 34'd1 << 31;
  localparam logic [33:0] QUARTER34   = 34'd1 << 30;
  localparam logic [33:0] THREEHALF34 = 34'd3 << 31;
  localparam logic [33:0] THREEQ34    = 34'd3 << 30;

  assign p34      = 34'(s2_p32_q);
  assign sine_sum = s2_p32_q[P32_W-1] ? (34'(SINE_FULL) - 34'(rom_data)) :
                                        (34'(SINE_FULL) + 34'(rom_data));

  always_comb begin
    level_d = '0;
    case (wave_sel_q)
      WAVE_SINE: begin
        level_d = (sine_sum[33:16] != '0) ? {LEVEL_W{1'b1}} : sine_sum[15:0];
      end
      WAVE_TRIANGLE: begin
        if (p34 < QUARTER34) begin
          level_d = q32_to_level(HALF34 + (p34 << 1));
        end else if (p34 < THREEQ34) begin
          level_d = q32_to_level(THREEHALF34 - (p34 << 1));
        end else begin
          level_d = q32_to_level((p34 << 1) - THREEHALF34);
        end
      end
      WAVE_SQUARE: begin
        level_d = s2_p32_q[P32_W-1] ? '0 : {LEVEL_W{1'b1}};
      end
      WAVE_SAW: begin
        level_d = {~s2_p32_q[P32_W-1], s2_p32_q[P32_W-2 -: LEVEL_W-1]};
      end
      WAVE_INV_SAW: begin
        level_d = s2_p32_q[P32_W-1] ? q32_to_level(THREEHALF34 - p34) :
                                      q32_to_level(HALF34 - p34);
      end
      default: level_d = '0;
    endcase
  end

  // Hold the result until the receiver takes it
  logic [LEVEL_W-1:0] level_q;
  logic [P32_W-1:0]   phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en3) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      level_q <= level_d;
      phase_q <= s2_p32_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign level_o     = level_q;
  assign phase_now_o = phase_q;

  // Checks
  `LFO_ASSERT(a_restart_zero,
      (in_valid_i && in_ready_o && restart_i && sample_count_i == '0) |=> (acc_q == '0),
      "restart with zero count left a nonzero phase")
  `LFO_ASSERT(a_acc_hold, !(in_valid_i && in_ready_o) |=> $stable(acc_q),
      "phase moved without an accepted beat")
  `LFO_ASSERT_IMPL(a_ready_full, !in_ready_o, s1_v_q && s2_v_q && out_v_q && !out_ready_i,
      "input stalled while the pipeline had room")
  `LFO_ASSERT_IMPL(a_square_rails, out_valid_o && wave_sel_q == WAVE_SQUARE,
      level_o == '0 || level_o == {LEVEL_W{1'b1}},
      "square level off the rails")

endmodule

[tb/tb_lfo_waveform_generator_unit.sv]
// Self-checking testbench for the LFO waveform generator unit.
`timescale 1ns / 1ps

module tb_lfo_waveform_generator_unit;

  localparam logic [63:0] SINE_DEPTH       = 64'd1024;
  localparam logic [12:0] MAX_BLOCK        = 13'd4096;
  localparam logic [63:0] Q30_UNIT         = 64'd1 << 30;
  localparam logic [63:0] Q30_QUARTER_TURN = 64'd1686629713;
  localparam logic [63:0] Q32_QUARTER      = 64'h0_4000_0000;
  localparam logic [63:0] Q32_HALF         = 64'h0_8000_0000;
  localparam logic [63:0] Q32_THREE_HALVES = 64'h1_8000_0000;
  localparam logic [lfo_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [2:0] WAVE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] WAVE_UNUSED_LAST  = 3'd7;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned LIMIT        = 400000;

  typedef struct packed {
    logic [lfo_pkg::LEVEL_W-1:0] level;
    logic [lfo_pkg::P32_W-1:0]   phase;
  } lfo_result_t;

  // Tracks the oscillator phase and predicts the level of every accepted beat
  class lfo_level_tracker;
    logic [31:0]  phase_acc;
    logic [30:0]  step;
    logic [2:0]   wave_sel;
    lfo_result_t  pending_q[$];
    int unsigned  fail_count;

    function new();
      phase_acc  = '0;
      step       = lfo_pkg::STEP_RESET;
      wave_sel   = lfo_pkg::WAVE_SINE;
      fail_count = 0;
    endfunction

    function void write_reg(input logic [lfo_pkg::CFG_IDX_W-1:0] idx,
                            input logic [31:0] data);
      case (idx)
        lfo_pkg::CFG_PHASE_STEP: step = data[30:0];
        lfo_pkg::CFG_WAVE_SEL:   wave_sel = data[2:0];
        default: ;
      endcase
    endfunction

    // Drop 16 fraction bits of a Q2.32 value, saturating at full scale
    function logic [15:0] level_of_q32(input logic [63:0] v);
      v = v >> 16;
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
    endfunction

    function logic [15:0] shape_level(input logic [31:0] p);
      logic [63:0] pp;
      logic [63:0] k;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] lv;
      pp = 64'(p);
      case (wave_sel)
        lfo_pkg::WAVE_SINE: begin
          // quarter-wave table position, mirrored in odd quadrants
          k = (64'(p[29:0]) * SINE_DEPTH) >> 30;
          if (p[30]) begin
            k = SINE_DEPTH - k;
          end
          x  = (k * Q30_QUARTER_TURN) / SINE_DEPTH;
          x2 = (x * x) >> 30;
          t  = Q30_UNIT - x2 / 64'd72;
          t  = Q30_UNIT - ((x2 * t) >> 30) / 64'd42;
          t  = Q30_UNIT - ((x2 * t) >> 30) / 64'd20;
          t  = Q30_UNIT - ((x2 * t) >> 30) / 64'd6;
          s  = (x * t) >> 30;
          s  = (s + (64'd1 << 14)) >> 15;
          if (s > 64'd32768) begin
            s = 64'd32768;
          end
          // negate in the lower half cycle
          lv = p[31] ? 64'd32768 - s : 64'd32768 + s;
          return (lv > 64'd65535) ? 16'hFFFF : lv[15:0];
        end
        lfo_pkg::WAVE_TRIANGLE: begin
          if (pp < Q32_QUARTER) begin
            return level_of_q32(Q32_HALF + 2 * pp);
          end else if (pp < 3 * Q32_QUARTER) begin
            return level_of_q32(Q32_THREE_HALVES - 2 * pp);
          end else begin
            return level_of_q32(2 * pp - Q32_THREE_HALVES);
          end
        end
        lfo_pkg::WAVE_SQUARE: return (pp < Q32_HALF) ? 16'hFFFF : 16'h0000;
        lfo_pkg::WAVE_SAW: begin
          return (pp < Q32_HALF) ? level_of_q32(Q32_HALF + pp) : level_of_q32(pp - Q32_HALF);
        end
        lfo_pkg::WAVE_INV_SAW: begin
          return (pp < Q32_HALF) ? level_of_q32(Q32_HALF - pp)
                                 : level_of_q32(Q32_THREE_HALVES - pp);
        end
        default: return 16'h0000;
      endcase
    endfunction

    // Advance the phase by one input beat and queue its expected result
    function void accept_block(input logic [12:0] count, input logic restart);
      logic [63:0]  advance;
      logic [12:0]  samples;
      lfo_result_t  res;
      samples = (count > MAX_BLOCK) ? MAX_BLOCK : count;
      if (restart) begin
        phase_acc = '0;
      end
      advance   = 64'(samples) * 64'(step);
      phase_acc = phase_acc + advance[31:0];
      res.level = shape_level(phase_acc);
      res.phase = phase_acc;
      pending_q.push_back(res);
    endfunction

    function void match_output(input logic [15:0] level, input logic [31:0] phase);
      lfo_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected output beat level=%0d phase=%h", $time, level, phase);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (level !== want.level) begin
          $display("%0t: level mismatch expected %0d actual %0d", $time, want.level, level);
          fail_count++;
        end
        if (phase !== want.phase) begin
          $display("%0t: phase mismatch expected %h actual %h", $time, want.phase, phase);
          fail_count++;
        end
      end
    endfunction

    function int unsigned outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [lfo_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [lfo_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [lfo_pkg::COUNT_W-1:0]    sample_count_i;
  logic                           restart_i;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [lfo_pkg::LEVEL_W-1:0]    level_o;
  logic [lfo_pkg::P32_W-1:0]      phase_now_o;

  lfo_level_tracker tracker = new();

  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_left = 0;
  int unsigned rx_mode = 0;

  lfo_waveform_generator_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_count_i (sample_count_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .level_o        (level_o),
    .phase_now_o    (phase_now_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Drive output backpressure: random modes, plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(4, 40);
      end
      rx_left--;
      case (rx_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Check every output beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.match_output(level_o, phase_now_o);
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Offer one input beat and hold it until accepted; returns at a falling edge
  task automatic push_item(input logic [12:0] count, input logic restart);
    in_valid_i     <= 1'b1;
    sample_count_i <= count;
    restart_i      <= restart;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    tracker.accept_block(count, restart);
    @(negedge clk_i);
  endtask

  // Write one register; valid is left high for the caller to drop
  task automatic write_cfg(input logic [lfo_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every predicted beat has come out
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (tracker.outstanding() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Reconfigure while idle, then stream random beats, bursty unless long_hold
  task automatic run_phase(input logic [31:0] step_word, input logic [2:0] wave_code,
                           input int unsigned n_items, input bit long_hold);
    logic [31:0] wave_word;
    logic [12:0] count;
    int unsigned burst_left;
    int unsigned gap;
    wait_results_drained();
    wave_word = $urandom();
    wave_word[2:0] = wave_code;
    write_cfg(lfo_pkg::CFG_WAVE_SEL, wave_word);
    write_cfg(lfo_pkg::CFG_PHASE_STEP, step_word);
    cfg_valid_i <= 1'b0;
    // restart at zero, then one oversized block
    push_item(13'd0, 1'b1);
    push_item(13'h1FFF, 1'b0);
    if (long_hold) begin
      hold_req = 1'b1;
    end
    burst_left = 0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (!long_hold && burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          gap = $urandom_range(1, 8);
          in_valid_i     <= 1'b0;
          sample_count_i <= 13'($urandom());
          restart_i      <= 1'($urandom());
          repeat (gap) @(negedge clk_i);
        end
      end
      if (burst_left != 0) begin
        burst_left--;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: count = 13'($urandom_range(0, 64));
        5, 6, 7:       count = 13'($urandom_range(0, 4096));
        8:             count = 13'($urandom_range(4090, 4102));
        default:       count = 13'($urandom_range(0, 8191));
      endcase
      push_item(count, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    logic [12:0] probe_counts [0:13];
    logic        probe_restart [0:13];
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    sample_count_i = '0;
    restart_i      = 1'b0;
    probe_counts  = '{13'd0, 13'd1, 13'd0, 13'd4096, 13'd4097, 13'h1FFF, 13'h1FFF,
                      13'd1, 13'd256, 13'd1024, 13'd4095, 13'd2048, 13'h1555, 13'h0AAA};
    probe_restart = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                      1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // field extremes, zero count and long blocks at the reset settings
    for (int i = 0; i < 14; i++) begin
      push_item(probe_counts[i], probe_restart[i]);
    end

    run_phase({1'b1, 31'h0010_0000}, lfo_pkg::WAVE_TRIANGLE, 70, 1'b0);
    run_phase(32'h7FFF_FFFF, lfo_pkg::WAVE_SQUARE, 70, 1'b1);
    run_phase(32'h0000_0000, lfo_pkg::WAVE_SAW, 40, 1'b0);
    run_phase($urandom(), lfo_pkg::WAVE_INV_SAW, 80, 1'b0);
    run_phase(32'($urandom_range(1, 1 << 16)), lfo_pkg::WAVE_SINE, 80, 1'b0);
    run_phase($urandom(), 3'($urandom_range(WAVE_UNUSED_FIRST, WAVE_UNUSED_LAST)), 40, 1'b0);
    // a write to an unmapped index must leave both registers alone
    wait_results_drained();
    write_cfg(CFG_SPARE, $urandom());
    cfg_valid_i <= 1'b0;
    push_item(13'd1024, 1'b1);
    run_phase(32'h0010_0000, lfo_pkg::WAVE_SINE, 70, 1'b0);
    run_phase($urandom(), lfo_pkg::WAVE_TRIANGLE, 70, 1'b0);
    run_phase($urandom(), lfo_pkg::WAVE_SAW, 60, 1'b0);
    run_phase(32'hFFFF_FFFF, lfo_pkg::WAVE_SINE, 70, 1'b0);
    run_phase(32'h0010_0000, lfo_pkg::WAVE_INV_SAW, 50, 1'b0);

    wait_results_drained();
    if (tracker.fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
